### hdl/itk_pkg.sv
`timescale 1ns / 1ps

package itk_pkg;

    // Field widths fixed by the interface
    localparam int SCORE_W = 32;
    localparam int CLASS_W = 10;
    localparam int TOPK_W  = 11;

    // Default row capacity
    localparam int MAX_CLASSES_DEF = 1024;

    // Configuration port
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_TOP_K   = 1'd0;
    localparam logic [TOPK_W-1:0]    TOP_K_RESET = 11'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // store the beat's score
        logic tgt_rd;   // read the true-class entry
        logic latch;    // capture the target, issue first row read
        logic scan;     // compare one entry, issue the next read
    } itk_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic oor;        // true class lies outside the row
        logic scan_done;  // walk finishes this cycle
    } itk_stat_t;

endpackage

### hdl/in_top_k_check.sv
`timescale 1ns / 1ps

// In-top-k check. Scores of a row arrive one beat per cycle on start while busy is
// low; the true class is taken from the first beat and last_in_row closes the row.
// If the true class lies outside the row, the result (in_top_k low,
// class_out_of_range high) appears in the cycle after the last beat and busy
// stays low. Otherwise busy rises and the stored row is walked through the
// single read port of the row memory: the target score is fetched first, then
// one entry per cycle is compared, ending early when the count of greater scores
// reaches top_k. done pulses for exactly one cycle with the result; the receiver
// cannot stall it and must take it in that cycle. Scores past MAX_CLASSES in one
// row are dropped. top_k resets to 1 and is written at byte address 0; the user
// must write it only while the block is idle, which the block does not enforce.
module in_top_k_check
    import itk_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [SCORE_W-1:0] score,
    input  logic [CLASS_W-1:0] true_class,
    input  logic               last_in_row,
    output logic               done,
    output logic               in_top_k,
    output logic               class_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    itk_cmd_t          cmd;
    itk_stat_t         stat;
    logic [TOPK_W-1:0] top_k_reg;
    logic [TOPK_W-1:0] top_k_next;
    logic              reg_hit;

    // Register decode
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_AW-1:2] == REG_TOP_K);

    always_comb
    begin
        top_k_next = top_k_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            top_k_next = pwdata[TOPK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg <= TOP_K_RESET;
        end
        else
        begin
            top_k_reg <= top_k_next;
        end
    end

    assign prdata = reg_hit ? APB_DW'(top_k_reg) : '0;

    // Sequencer
    itk_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_in_row (last_in_row),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy)
    );

    // Row store and compare
    itk_dp #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .score              (score),
        .true_class         (true_class),
        .last_in_row        (last_in_row),
        .top_k              (top_k_reg),
        .done               (done),
        .in_top_k           (in_top_k),
        .class_out_of_range (class_out_of_range)
    );

endmodule

### hdl/itk_ram.sv
`timescale 1ns / 1ps

module itk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/itk_ctrl.sv
`timescale 1ns / 1ps

module itk_ctrl
    import itk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      last_in_row,
    input  itk_stat_t stat,
    output itk_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_TGT   = 4'b0010,
        ST_LATCH = 4'b0100,
        ST_SCAN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands from the current state
    always_comb
    begin
        cmd.accept = (state_reg == ST_LOAD) && start;
        cmd.tgt_rd = (state_reg == ST_TGT);
        cmd.latch  = (state_reg == ST_LATCH);
        cmd.scan   = (state_reg == ST_SCAN);
    end

    assign busy = (state_reg != ST_LOAD);

    // Advance through load, target fetch and walk
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start && last_in_row && !stat.oor)
                begin
                    state_next = ST_TGT;
                end
            end
            ST_TGT:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/itk_dp.sv
`timescale 1ns / 1ps

module itk_dp
    import itk_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  itk_cmd_t           cmd,
    output itk_stat_t          stat,
    input  logic [SCORE_W-1:0] score,
    input  logic [CLASS_W-1:0] true_class,
    input  logic               last_in_row,
    input  logic [TOPK_W-1:0]  top_k,
    output logic               done,
    output logic               in_top_k,
    output logic               class_out_of_range
);

    localparam int IW  = $clog2(MAX_CLASSES);
    localparam int LW  = $clog2(MAX_CLASSES + 1);
    localparam int CW  = (IW > CLASS_W) ? IW : CLASS_W;
    localparam int CMW = (LW > CLASS_W) ? LW : CLASS_W;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_CLASSES);

    logic [LW-1:0]      len_reg, len_next;
    logic [CLASS_W-1:0] tc_reg, tc_next;
    logic [LW-1:0]      ptr_reg, ptr_next;
    logic [TOPK_W-1:0]  rank_reg, rank_next;
    logic [SCORE_W-1:0] target_reg, target_next;
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic               oor_reg, oor_next;

    logic               room;
    logic [LW-1:0]      len_after;
    logic [CLASS_W-1:0] eff_class;
    logic [CW-1:0]      tc_wide;
    logic               row_oor;
    logic               gt;
    logic [TOPK_W-1:0]  rank_new;
    logic               walk_end;
    logic               wr_en;
    logic [IW-1:0]      rd_addr;
    logic [SCORE_W-1:0] rd_data;

    // Row store
    itk_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_CLASSES)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (len_reg[IW-1:0]),
        .wdata (score),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Row bookkeeping for the incoming beat
    assign room      = (len_reg < LEN_MAX);
    assign len_after = room ? (len_reg + LW'(1)) : len_reg;
    assign eff_class = (len_reg == '0) ? true_class : tc_reg;
    assign row_oor   = (CMW'(eff_class) >= CMW'(len_after));
    assign wr_en     = cmd.accept && room;

    // Read address: target entry first, then the row in order
    assign tc_wide = CW'(tc_reg);
    assign rd_addr = cmd.tgt_rd ? tc_wide[IW-1:0] : ptr_reg[IW-1:0];

    // Compare one stored entry against the target
    assign gt       = ($signed(rd_data) > $signed(target_reg));
    assign rank_new = rank_reg + TOPK_W'(gt && (rank_reg < top_k));
    assign walk_end = (ptr_reg == len_reg) || (rank_new >= top_k);

    assign stat.oor       = row_oor;
    assign stat.scan_done = walk_end;

    always_comb
    begin
        len_next    = len_reg;
        tc_next     = tc_reg;
        ptr_next    = ptr_reg;
        rank_next   = rank_reg;
        target_next = target_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        oor_next    = oor_reg;

        if (cmd.accept)
        begin
            tc_next  = eff_class;
            len_next = len_after;
            if (last_in_row && row_oor)
            begin
                // Drop the row and report the bad class
                len_next  = '0;
                done_next = 1'b1;
                hit_next  = 1'b0;
                oor_next  = 1'b1;
            end
        end

        if (cmd.tgt_rd)
        begin
            ptr_next  = '0;
            rank_next = '0;
        end

        if (cmd.latch)
        begin
            target_next = rd_data;
            ptr_next    = ptr_reg + LW'(1);
        end

        if (cmd.scan)
        begin
            rank_next = rank_new;
            ptr_next  = ptr_reg + LW'(1);
            if (walk_end)
            begin
                len_next  = '0;
                done_next = 1'b1;
                hit_next  = (rank_new < top_k);
                oor_next  = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            tc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            tc_reg   <= tc_next;
            done_reg <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        rank_reg   <= rank_next;
        target_reg <= target_next;
        hit_reg    <= hit_next;
        oor_reg    <= oor_next;
    end

    assign done               = done_reg;
    assign in_top_k           = hit_reg;
    assign class_out_of_range = oor_reg;

endmodule
